/* rtl/core/mouse_packet_cursor_tracker_defines.svh */
// Assertion helpers for the mouse packet cursor tracker.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Checked only while out of reset.
`define MPCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MPCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mpct_pkg.sv */
`default_nettype none

package mpct_pkg;

  localparam int SCREEN_BITS = 13;
  localparam int DELTA_BITS  = 9;
  localparam int DELTA_Y_BITS = 10;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;
  localparam int POS_X_RESET = 512;
  localparam int POS_Y_RESET = 384;

  // Opcodes of the input channel.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Bit positions in the first byte of a packet.
  localparam int BIT_SYNC   = 3;
  localparam int BIT_X_SIGN = 4;
  localparam int BIT_Y_SIGN = 5;
  localparam int BIT_X_OVF  = 6;
  localparam int BIT_Y_OVF  = 7;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } byte_pos_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_PACKET = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [2:0]             buttons;
    logic [DELTA_BITS-1:0]  dx;
    logic [DELTA_BITS-1:0]  dy;
    logic                   ovf;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/mpct_in_if.sv */
`default_nettype none

interface mpct_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/mpct_out_if.sv */
`default_nettype none

interface mpct_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  packet_done;
  logic                  overflow_dropped;
  logic                  button_left;
  logic                  button_right;
  logic                  button_middle;
  logic signed [8:0]     delta_x;
  logic signed [9:0]     delta_y;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  moved_flag;
  logic                  event_pending;

  modport source (
    output valid, output packet_done, output overflow_dropped,
    output button_left, output button_right, output button_middle,
    output delta_x, output delta_y, output cursor_x, output cursor_y,
    output moved_flag, output event_pending, input ready
  );
  modport sink (
    input valid, input packet_done, input overflow_dropped,
    input button_left, input button_right, input button_middle,
    input delta_x, input delta_y, input cursor_x, input cursor_y,
    input moved_flag, input event_pending, output ready
  );
endinterface

`default_nettype wire

/* rtl/core/mpct_front.sv */
`default_nettype none

module mpct_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  mpct_in_if.sink            in_i,
  output mpct_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i
);

  mpct_pkg::byte_pos_e pos_q, pos_d;
  logic [7:0] flag_q, flag_d;
  logic [7:0] x_q, x_d;
  logic       accept;
  logic       is_byte;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign accept      = in_i.valid & cmd_ready_i;
  assign is_byte     = (in_i.opcode == mpct_pkg::OP_BYTE);

  // Next state of the packet assembler.
  always_comb begin
    pos_d  = pos_q;
    flag_d = flag_q;
    x_d    = x_q;
    if (accept && is_byte) begin
      case (pos_q)
        mpct_pkg::POS_SECOND: begin
          x_d   = in_i.rx_byte;
          pos_d = mpct_pkg::POS_THIRD;
        end
        mpct_pkg::POS_THIRD: begin
          pos_d = mpct_pkg::POS_FIRST;
        end
        default: begin
          // A first byte must carry the sync bit, or it is dropped.
          if (in_i.rx_byte[mpct_pkg::BIT_SYNC]) begin
            flag_d = in_i.rx_byte;
            pos_d  = mpct_pkg::POS_SECOND;
          end else begin
            pos_d = mpct_pkg::POS_FIRST;
          end
        end
      endcase
    end
  end

  // Command handed to the back end for each beat.
  always_comb begin
    cmd_o.kind    = mpct_pkg::CMD_NONE;
    cmd_o.buttons = flag_q[2:0];
    cmd_o.dx      = {flag_q[mpct_pkg::BIT_X_SIGN], x_q};
    cmd_o.dy      = {flag_q[mpct_pkg::BIT_Y_SIGN], in_i.rx_byte};
    cmd_o.ovf     = flag_q[mpct_pkg::BIT_X_OVF] | flag_q[mpct_pkg::BIT_Y_OVF];
    if (!is_byte) begin
      cmd_o.kind = mpct_pkg::CMD_CLEAR;
    end else if (pos_q == mpct_pkg::POS_THIRD) begin
      cmd_o.kind = mpct_pkg::CMD_PACKET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= mpct_pkg::POS_FIRST;
      flag_q <= '0;
      x_q    <= '0;
    end else begin
      pos_q  <= pos_d;
      flag_q <= flag_d;
      x_q    <= x_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mpct_queue.sv */
`default_nettype none

module mpct_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mpct_pkg::cmd_t  push_data_i,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  output mpct_pkg::cmd_t       pop_data_o,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i
);

  localparam int Depth = 2;
  localparam logic [1:0] Full = 2'(Depth);

  mpct_pkg::cmd_t mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mpct_back.sv */
`default_nettype none

module mpct_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mpct_pkg::cmd_t                    cmd_i,
  input  wire logic                              cmd_valid_i,
  output logic                                   cmd_ready_o,
  input  wire logic [mpct_pkg::SCREEN_BITS-1:0]  screen_width_i,
  input  wire logic [mpct_pkg::SCREEN_BITS-1:0]  screen_height_i,
  mpct_out_if.source                             out_o
);

  localparam int SumW = COORD_BITS + 2;
  localparam int LimW = (COORD_BITS > mpct_pkg::SCREEN_BITS) ? COORD_BITS
                                                            : mpct_pkg::SCREEN_BITS;
  localparam int CoordMaxI = (1 << COORD_BITS) - 1;
  localparam int PosXRstI  = (mpct_pkg::POS_X_RESET > CoordMaxI) ? CoordMaxI
                                                                : mpct_pkg::POS_X_RESET;
  localparam int PosYRstI  = (mpct_pkg::POS_Y_RESET > CoordMaxI) ? CoordMaxI
                                                                : mpct_pkg::POS_Y_RESET;
  localparam logic [COORD_BITS-1:0] CoordMax = {COORD_BITS{1'b1}};

  function automatic logic [COORD_BITS-1:0] axis_limit(
    input logic [mpct_pkg::SCREEN_BITS-1:0] size
  );
    logic [LimW-1:0] lim;
    lim = LimW'(size - mpct_pkg::SCREEN_BITS'(1));
    if (size == '0) begin
      return '0;
    end else if (lim > LimW'(CoordMax)) begin
      return CoordMax;
    end
    return lim[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_move(
    input logic [COORD_BITS-1:0] pos,
    input logic signed [9:0]     delta,
    input logic [COORD_BITS-1:0] limit
  );
    logic signed [SumW-1:0] n;
    n = $signed({2'b00, pos}) + SumW'(delta);
    if (n < 0) begin
      return '0;
    end else if (n > $signed({2'b00, limit})) begin
      return limit;
    end
    return n[COORD_BITS-1:0];
  endfunction

  logic                    out_valid_q, out_valid_d;
  logic                    done_q, done_d;
  logic                    ovf_q, ovf_d;
  logic [2:0]              buttons_q, buttons_d;
  logic signed [8:0]       last_dx_q, last_dx_d;
  logic signed [9:0]       last_dy_q, last_dy_d;
  logic [COORD_BITS-1:0]   pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0]   pos_y_q, pos_y_d;
  logic                    moved_q, moved_d;
  logic                    event_q, event_d;
  logic                    pop;
  logic signed [9:0]       dx_ext;
  logic signed [9:0]       ndy;
  logic [COORD_BITS-1:0]   new_x, new_y;

  // The state registers double as the output register: they only change
  // when the previous beat has been taken.
  assign cmd_ready_o = ~out_valid_q | out_o.ready;
  assign pop         = cmd_valid_i & cmd_ready_o;

  assign dx_ext = $signed({cmd_i.dx[8], cmd_i.dx});
  assign ndy    = -$signed({cmd_i.dy[8], cmd_i.dy});
  assign new_x  = clamp_move(pos_x_q, dx_ext, axis_limit(screen_width_i));
  assign new_y  = clamp_move(pos_y_q, ndy, axis_limit(screen_height_i));

  always_comb begin
    out_valid_d = out_valid_q & ~out_o.ready;
    done_d      = done_q;
    ovf_d       = ovf_q;
    buttons_d   = buttons_q;
    last_dx_d   = last_dx_q;
    last_dy_d   = last_dy_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    moved_d     = moved_q;
    event_d     = event_q;
    if (pop) begin
      out_valid_d = 1'b1;
      done_d      = 1'b0;
      ovf_d       = 1'b0;
      case (cmd_i.kind)
        mpct_pkg::CMD_CLEAR: begin
          moved_d = 1'b0;
          event_d = 1'b0;
        end
        mpct_pkg::CMD_PACKET: begin
          done_d    = 1'b1;
          buttons_d = cmd_i.buttons;
          if (cmd_i.ovf) begin
            ovf_d = 1'b1;
          end else begin
            last_dx_d = $signed(cmd_i.dx);
            last_dy_d = ndy;
            pos_x_d   = new_x;
            pos_y_d   = new_y;
            if (new_x != pos_x_q || new_y != pos_y_q) begin
              moved_d = 1'b1;
            end
            event_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      ovf_q       <= 1'b0;
      buttons_q   <= '0;
      last_dx_q   <= '0;
      last_dy_q   <= '0;
      pos_x_q     <= COORD_BITS'(PosXRstI);
      pos_y_q     <= COORD_BITS'(PosYRstI);
      moved_q     <= 1'b0;
      event_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
      ovf_q       <= ovf_d;
      buttons_q   <= buttons_d;
      last_dx_q   <= last_dx_d;
      last_dy_q   <= last_dy_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      moved_q     <= moved_d;
      event_q     <= event_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.packet_done      = done_q;
  assign out_o.overflow_dropped = ovf_q;
  assign out_o.button_left      = buttons_q[0];
  assign out_o.button_right     = buttons_q[1];
  assign out_o.button_middle    = buttons_q[2];
  assign out_o.delta_x          = last_dx_q;
  assign out_o.delta_y          = last_dy_q;
  assign out_o.cursor_x         = pos_x_q;
  assign out_o.cursor_y         = pos_y_q;
  assign out_o.moved_flag       = moved_q;
  assign out_o.event_pending    = event_q;

endmodule

`default_nettype wire

/* rtl/core/mouse_packet_cursor_tracker.sv */
// Mouse packet cursor tracker.
// Input channel in_i carries one beat per mouse byte (opcode byte) or a
// clear request (opcode clear). Output channel out_o returns exactly one
// beat per input beat, in order: button state, last deltas, cursor
// position and the moved/event flags, plus packet_done and
// overflow_dropped for the byte that closed a three-byte packet.
// Screen width and height are set over the APB port at byte addresses 0
// and 4; they clamp the cursor on the next completed packet.
// Throughput is one beat per cycle while out_o is not stalled. An input
// beat is written into the command queue when it is accepted, and the
// back end loads its result into the result register when it pops that
// queue entry. The front end classifies and assembles bytes, a two-entry
// command queue decouples it from the back end that owns the cursor state
// and output register.
// Reset clears packet assembly, flags, buttons and deltas, centers the
// cursor on the default 1024x768 screen and restores the screen size.
// When the receiver stalls, the output beat holds, the queue fills, and
// in_i.ready drops once both queue entries are taken: after one more beat
// while streaming, after two when the queue was empty.
`default_nettype none

module mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mpct_in_if.sink          in_i,
  mpct_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [mpct_pkg::SCREEN_BITS-1:0] width_q, height_q;
  logic                             cfg_wr;
  mpct_pkg::cmd_t                   front_cmd, back_cmd;
  logic                             front_valid, front_ready;
  logic                             back_valid, back_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mpct_pkg::SCREEN_WIDTH_RESET;
      height_q <= mpct_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        mpct_pkg::REG_WIDTH:  width_q  <= pwdata[mpct_pkg::SCREEN_BITS-1:0];
        mpct_pkg::REG_HEIGHT: height_q <= pwdata[mpct_pkg::SCREEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mpct_pkg::REG_WIDTH:  prdata = 32'(width_q);
      mpct_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:              prdata = '0;
    endcase
  end

  mpct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  mpct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  mpct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (back_cmd),
    .cmd_valid_i     (back_valid),
    .cmd_ready_o     (back_ready),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .out_o           (out_o)
  );

endmodule

`default_nettype wire

/* rtl/core/mpct_checker.sv */
`default_nettype none
`include "mouse_packet_cursor_tracker_defines.svh"

module mpct_checker #(
  parameter int COORD_BITS = 12
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic                  out_done_i,
  input wire logic                  out_ovf_i,
  input wire logic [COORD_BITS-1:0] out_cursor_x_i,
  input wire logic [COORD_BITS-1:0] out_cursor_y_i,
  input wire logic                  out_moved_i,
  input wire logic                  out_event_i
);

  `MPCT_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_i, "beat shown in reset")

  `MPCT_ASSERT(a_ovf_done, clk_i, rst_ni, out_valid_i && out_ovf_i |-> out_done_i, "overflow without packet")

  // The moved flag is only ever set together with the event flag.
  `MPCT_ASSERT(a_moved_event, clk_i, rst_ni, out_moved_i |-> out_event_i, "moved without event")

  `MPCT_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_cursor_x_i) && $stable(out_cursor_y_i) && $stable(out_done_i), "stalled beat changed")

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(
  .COORD_BITS (COORD_BITS)
) u_mpct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_done_i     (out_o.packet_done),
  .out_ovf_i      (out_o.overflow_dropped),
  .out_cursor_x_i (out_o.cursor_x),
  .out_cursor_y_i (out_o.cursor_y),
  .out_moved_i    (out_o.moved_flag),
  .out_event_i    (out_o.event_pending)
);

`default_nettype wire
